/* rtl/core/timer8_prescaler_ctc_pwm_core_assert.svh */
// ----------------------------------------------------------------------------
// timer8 assertion macros
// shared property forms for the timer core, clocked on clk, reset on rst_n
// ----------------------------------------------------------------------------
`ifndef TIMER8_PRESCALER_CTC_PWM_CORE_ASSERT_SVH
`define TIMER8_PRESCALER_CTC_PWM_CORE_ASSERT_SVH

// same-cycle implication
`define TMR8_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer8 core check failed");

// next-cycle implication
`define TMR8_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer8 core check failed");

`endif

/* rtl/core/tmr8_pkg.sv */
// ----------------------------------------------------------------------------
// tmr8_pkg
// request kinds, register map, mode codes and output action helper
// ----------------------------------------------------------------------------
`default_nettype none

package tmr8_pkg;

    // request kinds
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_TICK  = 2'd0;
    localparam kind_t KIND_WRITE = 2'd1;
    localparam kind_t KIND_READ  = 2'd2;

    // register map
    typedef logic [2:0] reg_sel_t;
    localparam reg_sel_t REG_CONTROL = 3'd0;
    localparam reg_sel_t REG_COUNT   = 3'd1;
    localparam reg_sel_t REG_COMPARE = 3'd2;
    localparam reg_sel_t REG_FLAGS   = 3'd3;
    localparam reg_sel_t REG_MASK    = 3'd4;

    // waveform generation modes, {control[6], control[3]}
    typedef logic [1:0] wgm_t;
    localparam wgm_t WGM_NORMAL = 2'b00;
    localparam wgm_t WGM_CTC    = 2'b01;
    localparam wgm_t WGM_FAST   = 2'b11;

    // compare output actions, control[5:4]
    typedef logic [1:0] com_t;
    localparam com_t COM_NONE   = 2'd0;
    localparam com_t COM_TOGGLE = 2'd1;
    localparam com_t COM_CLEAR  = 2'd2;
    localparam com_t COM_SET    = 2'd3;

    // clock selects, control[2:0]
    typedef logic [2:0] cs_t;
    localparam cs_t CS_STOP    = 3'd0;
    localparam cs_t CS_DIV1    = 3'd1;
    localparam cs_t CS_DIV8    = 3'd2;
    localparam cs_t CS_DIV64   = 3'd3;
    localparam cs_t CS_DIV256  = 3'd4;
    localparam cs_t CS_DIV1024 = 3'd5;

    localparam logic [7:0] CONTROL_WR_MASK = 8'h7F;
    localparam logic [7:0] COUNT_TOP       = 8'hFF;

    // flag bits
    localparam int FLAG_OVF = 0;
    localparam int FLAG_CMP = 1;

    // non-pwm output action on a match or a forced compare
    function automatic logic apply_action(input com_t com, input logic level);
        logic res;
        begin
            res = level;
            case (com)
                COM_TOGGLE: res = ~level;
                COM_CLEAR:  res = 1'b0;
                COM_SET:    res = 1'b1;
                default:    res = level;
            endcase
            return res;
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/timer8_prescaler_ctc_pwm_core.sv */
// ----------------------------------------------------------------------------
// timer8_prescaler_ctc_pwm_core
// 8-bit timer/counter with prescaler, normal, ctc and fast pwm modes
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready) carries one request: a clock tick, a
//   register write or a register read (mode, reg_select, write_data).
//   out channel (out_valid/out_ready) returns one result per request:
//   read_data (zero unless a read), wave_out and both interrupt lines as
//   they stand after that request.
//   the result is registered and presented in the cycle after the request is taken.
//   throughput: one request per cycle; the whole update is a single pass of
//   logic from the timer state and the request into the state registers and
//   the result register.
//   a new request is taken while the held result is being taken in the same
//   cycle; when the receiver stalls with a result held, in_ready drops and
//   the result and the timer state stay as they are.
//   reset clears the control byte (timer stopped), counter, compare value
//   and buffer, flags, mask, prescaler and wave level, and empties the
//   result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timer8_prescaler_ctc_pwm_core_assert.svh"

module timer8_prescaler_ctc_pwm_core
    import tmr8_pkg::*;
#(
    parameter int PRESCALE_BITS = 10
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] mode,
    input  wire logic [2:0] reg_select,
    input  wire logic [7:0] write_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      read_data,
    output logic            wave_out,
    output logic            overflow_irq,
    output logic            compare_irq
);

    // timer state
    logic [7:0]               control_reg, control_next;
    logic [7:0]               count_reg, count_next;
    logic [7:0]               compare_reg, compare_next;
    logic [7:0]               cmp_buf_reg, cmp_buf_next;
    logic [1:0]               flags_reg, flags_next;
    logic [1:0]               irq_mask_reg, irq_mask_next;
    logic [PRESCALE_BITS-1:0] prescale_reg, prescale_next;
    logic                     wave_reg, wave_next;
    logic                     blk_reg, blk_next;

    // result register
    logic       out_valid_reg;
    logic [7:0] rd_reg, rd_next;
    logic       pin_reg, pin_next;
    logic       ovf_irq_reg, cmp_irq_reg;

    logic  in_accept;
    logic  tap_hit;
    logic  match;
    wgm_t  wgm, wgm_new;
    com_t  com, com_new;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    assign wgm = {control_reg[6], control_reg[3]};
    assign com = control_reg[5:4];

    // next state for one request
    always_comb
    begin
        control_next  = control_reg;
        count_next    = count_reg;
        compare_next  = compare_reg;
        cmp_buf_next  = cmp_buf_reg;
        flags_next    = flags_reg;
        irq_mask_next = irq_mask_reg;
        prescale_next = prescale_reg;
        wave_next     = wave_reg;
        blk_next      = blk_reg;
        rd_next       = 8'h00;
        tap_hit       = 1'b0;
        match         = 1'b0;

        case (mode)
            KIND_TICK:
            begin
                prescale_next = prescale_reg + 1'b1;
                // prescaler tap for the selected clock
                case (cs_t'(control_reg[2:0]))
                    CS_DIV1:    tap_hit = 1'b1;
                    CS_DIV8:    tap_hit = (prescale_next[2:0] == 3'd0);
                    CS_DIV64:   tap_hit = (prescale_next[5:0] == 6'd0);
                    CS_DIV256:  tap_hit = (prescale_next[7:0] == 8'd0);
                    CS_DIV1024: tap_hit = (prescale_next[9:0] == 10'd0);
                    default:    tap_hit = 1'b0;
                endcase
                if (tap_hit)
                begin
                    match    = (count_reg == compare_reg) && !blk_reg;
                    blk_next = 1'b0;
                    if (match)
                    begin
                        flags_next[FLAG_CMP] = 1'b1;
                    end
                    if (wgm == WGM_FAST)
                    begin
                        // fast pwm: match then top handling
                        if (match && com == COM_CLEAR)
                        begin
                            wave_next = 1'b0;
                        end
                        else if (match && com == COM_SET)
                        begin
                            wave_next = 1'b1;
                        end
                        if (count_reg == COUNT_TOP)
                        begin
                            count_next           = 8'h00;
                            flags_next[FLAG_OVF] = 1'b1;
                            compare_next         = cmp_buf_reg;
                            if (com == COM_CLEAR)
                            begin
                                wave_next = 1'b1;
                            end
                            else if (com == COM_SET)
                            begin
                                wave_next = 1'b0;
                            end
                        end
                        else
                        begin
                            count_next = count_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        // normal and ctc
                        if (match)
                        begin
                            wave_next = apply_action(com, wave_reg);
                        end
                        if (wgm == WGM_CTC && match)
                        begin
                            count_next = 8'h00;
                        end
                        else if (count_reg == COUNT_TOP)
                        begin
                            count_next           = 8'h00;
                            flags_next[FLAG_OVF] = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + 8'd1;
                        end
                    end
                end
            end
            KIND_WRITE:
            begin
                case (reg_select)
                    REG_CONTROL:
                    begin
                        control_next = write_data & CONTROL_WR_MASK;
                        if (write_data[7] && wgm_new != WGM_FAST)
                        begin
                            wave_next = apply_action(com_new, wave_reg);
                        end
                    end
                    REG_COUNT:
                    begin
                        count_next = write_data;
                        blk_next   = 1'b1;
                    end
                    REG_COMPARE:
                    begin
                        cmp_buf_next = write_data;
                        if (wgm != WGM_FAST)
                        begin
                            compare_next = write_data;
                        end
                    end
                    REG_FLAGS:   flags_next    = flags_reg & ~write_data[1:0];
                    REG_MASK:    irq_mask_next = write_data[1:0];
                    default:     ;
                endcase
            end
            KIND_READ:
            begin
                case (reg_select)
                    REG_CONTROL: rd_next = control_reg;
                    REG_COUNT:   rd_next = count_reg;
                    REG_COMPARE: rd_next = cmp_buf_reg;
                    REG_FLAGS:   rd_next = {6'd0, flags_reg};
                    REG_MASK:    rd_next = {6'd0, irq_mask_reg};
                    default:     rd_next = 8'h00;
                endcase
            end
            default: ;
        endcase
    end

    // mode and action of a control byte being written
    assign wgm_new = {write_data[6], write_data[3]};
    assign com_new = write_data[5:4];

    // pin level after the request
    always_comb
    begin
        if (control_next[5:4] == COM_NONE ||
            ({control_next[6], control_next[3]} == WGM_FAST &&
             control_next[5:4] == COM_TOGGLE))
        begin
            pin_next = 1'b0;
        end
        else
        begin
            pin_next = wave_next;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg  <= '0;
            count_reg    <= '0;
            compare_reg  <= '0;
            cmp_buf_reg  <= '0;
            flags_reg    <= '0;
            irq_mask_reg <= '0;
            prescale_reg <= '0;
            wave_reg     <= 1'b0;
            blk_reg      <= 1'b0;
        end
        else if (in_accept)
        begin
            control_reg  <= control_next;
            count_reg    <= count_next;
            compare_reg  <= compare_next;
            cmp_buf_reg  <= cmp_buf_next;
            flags_reg    <= flags_next;
            irq_mask_reg <= irq_mask_next;
            prescale_reg <= prescale_next;
            wave_reg     <= wave_next;
            blk_reg      <= blk_next;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rd_reg      <= rd_next;
            pin_reg     <= pin_next;
            ovf_irq_reg <= flags_next[FLAG_OVF] & irq_mask_next[FLAG_OVF];
            cmp_irq_reg <= flags_next[FLAG_CMP] & irq_mask_next[FLAG_CMP];
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = rd_reg;
    assign wave_out     = pin_reg;
    assign overflow_irq = ovf_irq_reg;
    assign compare_irq  = cmp_irq_reg;

    // checks
    `TMR8_ASSERT_IMPL(a_ovf_irq_tracks_state, out_valid_reg,
        ovf_irq_reg == (flags_reg[FLAG_OVF] & irq_mask_reg[FLAG_OVF]))
    `TMR8_ASSERT_IMPL(a_cmp_irq_tracks_state, out_valid_reg,
        cmp_irq_reg == (flags_reg[FLAG_CMP] & irq_mask_reg[FLAG_CMP]))
    `TMR8_ASSERT_NEXT(a_no_read_zero_data, in_accept && mode != KIND_READ,
        rd_reg == 8'h00)
    `TMR8_ASSERT_NEXT(a_stopped_count_holds,
        in_accept && mode == KIND_TICK && control_reg[2:0] == CS_STOP,
        $stable(count_reg))

endmodule

`default_nettype wire

/* verif/timer8_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timer8_result_checker
// watches the request and result channels of the timer core, keeps its own
// copy of the timer state, predicts each result and compares field by field
// ----------------------------------------------------------------------------

module timer8_result_checker
    import tmr8_pkg::*;
#(
    parameter int PRESCALE_BITS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  kind_t       mode,
    input  reg_sel_t    reg_select,
    input  logic [7:0]  write_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  read_data,
    input  logic        wave_out,
    input  logic        overflow_irq,
    input  logic        compare_irq,
    output int          fail_count,
    output int          pending,
    output int          checked,
    output int          timer_clocks
);

    typedef struct packed {
        logic [7:0] read_data;
        logic       wave_out;
        logic       ovf_irq;
        logic       cmp_irq;
    } timer_result_t;

    // timer state as the core should hold it
    logic [7:0]               ctl_q;
    logic [7:0]               count_q;
    logic [7:0]               cmp_active;
    logic [7:0]               cmp_buffer;
    logic [1:0]               flags_q;
    logic [1:0]               mask_q;
    logic [PRESCALE_BITS-1:0] prescale_q;
    logic                     level_q;
    logic                     count_written;

    timer_result_t expected_results[$];

    function automatic wgm_t wave_mode_of(input logic [7:0] ctl);
        return {ctl[6], ctl[3]};
    endfunction

    // pin level after a non-pwm match or a forced compare
    function automatic logic next_level(input com_t act, input logic lvl);
        case (act)
            COM_TOGGLE: return ~lvl;
            COM_CLEAR:  return 1'b0;
            COM_SET:    return 1'b1;
            default:    return lvl;
        endcase
    endfunction

    // one timer clock: compare match, counter step, overflow
    task automatic timer_clock_step();
        wgm_t w;
        com_t act;
        logic hit;
        begin
            w     = wave_mode_of(ctl_q);
            act   = com_t'(ctl_q[5:4]);
            hit   = (count_q == cmp_active) && !count_written;
            count_written = 1'b0;
            timer_clocks++;
            if (w == WGM_FAST) begin
                if (hit) begin
                    flags_q[FLAG_CMP] = 1'b1;
                    if (act == COM_CLEAR)
                        level_q = 1'b0;
                    else if (act == COM_SET)
                        level_q = 1'b1;
                end
                if (count_q == COUNT_TOP) begin
                    count_q           = 8'h00;
                    flags_q[FLAG_OVF] = 1'b1;
                    cmp_active        = cmp_buffer;
                    if (act == COM_CLEAR)
                        level_q = 1'b1;
                    else if (act == COM_SET)
                        level_q = 1'b0;
                end
                else begin
                    count_q = count_q + 8'd1;
                end
            end
            else begin
                if (hit) begin
                    flags_q[FLAG_CMP] = 1'b1;
                    level_q = next_level(act, level_q);
                end
                if (w == WGM_CTC && hit)
                    count_q = 8'h00;
                else if (count_q == COUNT_TOP) begin
                    count_q           = 8'h00;
                    flags_q[FLAG_OVF] = 1'b1;
                end
                else
                    count_q = count_q + 8'd1;
            end
        end
    endtask

    // apply one request to the state and work out its result
    task automatic predict_result(input kind_t k, input reg_sel_t sel,
                                  input logic [7:0] d, output timer_result_t res);
        int   tap;
        com_t act;
        begin
            res = '0;
            case (k)
                KIND_TICK: begin
                    prescale_q = prescale_q + 1'b1;
                    case (cs_t'(ctl_q[2:0]))
                        CS_DIV1:    tap = 1;
                        CS_DIV8:    tap = 8;
                        CS_DIV64:   tap = 64;
                        CS_DIV256:  tap = 256;
                        CS_DIV1024: tap = 1024;
                        default:    tap = 0;
                    endcase
                    if (tap != 0 && (int'(prescale_q) & (tap - 1)) == 0)
                        timer_clock_step();
                end
                KIND_WRITE: begin
                    case (sel)
                        REG_CONTROL: begin
                            ctl_q = d & CONTROL_WR_MASK;
                            // force compare strobe, no flag, not in fast pwm
                            if (d[7] && wave_mode_of(ctl_q) != WGM_FAST)
                                level_q = next_level(com_t'(ctl_q[5:4]), level_q);
                        end
                        REG_COUNT: begin
                            count_q       = d;
                            count_written = 1'b1;
                        end
                        REG_COMPARE: begin
                            cmp_buffer = d;
                            if (wave_mode_of(ctl_q) != WGM_FAST)
                                cmp_active = d;
                        end
                        REG_FLAGS: flags_q = flags_q & ~d[1:0];
                        REG_MASK:  mask_q  = d[1:0];
                        default: ;
                    endcase
                end
                KIND_READ: begin
                    case (sel)
                        REG_CONTROL: res.read_data = ctl_q;
                        REG_COUNT:   res.read_data = count_q;
                        REG_COMPARE: res.read_data = cmp_buffer;
                        REG_FLAGS:   res.read_data = {6'd0, flags_q};
                        REG_MASK:    res.read_data = {6'd0, mask_q};
                        default:     res.read_data = 8'h00;
                    endcase
                end
                default: ;
            endcase
            // output pin is disconnected for no action, or toggle in fast pwm
            act = com_t'(ctl_q[5:4]);
            if (act == COM_NONE || (wave_mode_of(ctl_q) == WGM_FAST && act == COM_TOGGLE))
                res.wave_out = 1'b0;
            else
                res.wave_out = level_q;
            res.ovf_irq = flags_q[FLAG_OVF] & mask_q[FLAG_OVF];
            res.cmp_irq = flags_q[FLAG_CMP] & mask_q[FLAG_CMP];
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // results are compared before the request of the same edge is predicted
    always @(posedge clk or negedge rst_n) begin
        timer_result_t want;
        timer_result_t nxt;
        if (!rst_n) begin
            ctl_q         = 8'h00;
            count_q       = 8'h00;
            cmp_active    = 8'h00;
            cmp_buffer    = 8'h00;
            flags_q       = 2'b00;
            mask_q        = 2'b00;
            prescale_q    = '0;
            level_q       = 1'b0;
            count_written = 1'b0;
            expected_results.delete();
            fail_count    = 0;
            pending       = 0;
            checked       = 0;
            timer_clocks  = 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else begin
                    want = expected_results.pop_front();
                    check_field("read_data", want.read_data, read_data);
                    check_field("wave_out", {7'd0, want.wave_out}, {7'd0, wave_out});
                    check_field("overflow_irq", {7'd0, want.ovf_irq}, {7'd0, overflow_irq});
                    check_field("compare_irq", {7'd0, want.cmp_irq}, {7'd0, compare_irq});
                    checked++;
                end
            end
            if (in_valid && in_ready) begin
                predict_result(mode, reg_select, write_data, nxt);
                expected_results.push_back(nxt);
            end
            pending = expected_results.size();
        end
    end

endmodule

/* verif/timer8_prescaler_ctc_pwm_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timer8_prescaler_ctc_pwm_core_tb
// drives ticks, register writes and reads into the timer core with bursty
// requests and a stalling receiver; the checker beside the core predicts
// and compares every result, this top gives the verdict
// ----------------------------------------------------------------------------

module timer8_prescaler_ctc_pwm_core_tb;

    import tmr8_pkg::*;

    localparam int       ITEM_TARGET   = 1700;
    localparam int       IDLE_LIMIT    = 2000;
    localparam int       HOLD_CYCLES   = 60;
    localparam kind_t    KIND_SPARE    = 2'd3;
    localparam reg_sel_t REG_UNUSED_LO = 3'd5;
    localparam reg_sel_t REG_UNUSED_HI = 3'd7;
    localparam cs_t      CS_EXT_FALL   = 3'd6;
    localparam cs_t      CS_EXT_RISE   = 3'd7;
    localparam wgm_t     WGM_PHASE     = 2'b10;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    kind_t      mode;
    reg_sel_t   reg_select;
    logic [7:0] write_data;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] read_data;
    logic       wave_out;
    logic       overflow_irq;
    logic       compare_irq;

    int fail_count;
    int pending;
    int checked;
    int timer_clocks;

    int burst_left;
    int sent;
    int stall_cycles;
    bit idle_on;
    bit hold_req;

    always #5 clk = ~clk;

    timer8_prescaler_ctc_pwm_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .reg_select   (reg_select),
        .write_data   (write_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_data    (read_data),
        .wave_out     (wave_out),
        .overflow_irq (overflow_irq),
        .compare_irq  (compare_irq)
    );

    timer8_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .reg_select   (reg_select),
        .write_data   (write_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_data    (read_data),
        .wave_out     (wave_out),
        .overflow_irq (overflow_irq),
        .compare_irq  (compare_irq),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked),
        .timer_clocks (timer_clocks)
    );

    // control byte from its parts
    function automatic logic [7:0] make_ctl(input bit force_cmp, input wgm_t w,
                                            input com_t act, input cs_t sel);
        return {force_cmp, w[1], act, w[0], sel};
    endfunction

    // offer one request and hold it until taken; bursts with random gaps
    task automatic issue(input kind_t k, input reg_sel_t sel, input logic [7:0] d);
        int gap;
        begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 20);
                gap = (!idle_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
            in_valid   <= 1'b1;
            mode       <= k;
            reg_select <= sel;
            write_data <= d;
            do
                @(posedge clk);
            while (!in_ready);
            sent++;
            @(negedge clk);
        end
    endtask

    task automatic wait_for_drain();
        in_valid  <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    // one random scenario: set up the timer, then mostly ticks with accesses
    task automatic random_segment();
        int         r;
        int         n;
        cs_t        sel;
        wgm_t       w;
        logic [7:0] cmp_v;
        begin
            r = $urandom_range(0, 99);
            if (r < 55)      sel = CS_DIV1;
            else if (r < 75) sel = CS_DIV8;
            else if (r < 85) sel = CS_DIV64;
            else if (r < 88) sel = CS_DIV256;
            else if (r < 90) sel = CS_DIV1024;
            else if (r < 94) sel = CS_STOP;
            else             sel = ($urandom_range(0, 1) == 0) ? CS_EXT_FALL : CS_EXT_RISE;
            case ($urandom_range(0, 7))
                0, 1:    w = WGM_NORMAL;
                2, 3:    w = WGM_CTC;
                4, 5, 6: w = WGM_FAST;
                default: w = WGM_PHASE;
            endcase
            issue(KIND_WRITE, REG_CONTROL,
                  make_ctl($urandom_range(0, 3) == 0, w, com_t'($urandom_range(0, 3)), sel));

            case ($urandom_range(0, 4))
                0:       cmp_v = 8'h00;
                1:       cmp_v = COUNT_TOP;
                2:       cmp_v = 8'($urandom_range(1, 12));
                default: cmp_v = 8'($urandom_range(0, 255));
            endcase
            if ($urandom_range(0, 2) != 0)
                issue(KIND_WRITE, REG_COMPARE, cmp_v);
            // start the counter close to a match or to top, or at a random value
            case ($urandom_range(0, 3))
                0: issue(KIND_WRITE, REG_COUNT, cmp_v - 8'($urandom_range(0, 3)));
                1: issue(KIND_WRITE, REG_COUNT, COUNT_TOP - 8'($urandom_range(0, 3)));
                2: issue(KIND_WRITE, REG_COUNT, 8'($urandom_range(0, 255)));
                default: ;
            endcase

            n = $urandom_range(4, 40);
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    issue(KIND_TICK, reg_sel_t'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
                else if (r < 83)
                    issue(KIND_READ, reg_sel_t'($urandom_range(REG_CONTROL, REG_MASK)), 8'h00);
                else if (r < 88)
                    issue(KIND_WRITE, REG_FLAGS, 8'($urandom_range(0, 255)));
                else if (r < 91)
                    issue(KIND_WRITE, REG_MASK, 8'($urandom_range(0, 255)));
                else if (r < 94)
                    issue(KIND_WRITE, REG_COMPARE, 8'($urandom_range(0, 255)));
                else if (r < 96)
                    issue(KIND_WRITE, REG_COUNT, 8'($urandom_range(0, 255)));
                else if (r < 98)
                    issue(KIND_SPARE, reg_sel_t'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
                else
                    issue(($urandom_range(0, 1) == 0) ? KIND_WRITE : KIND_READ,
                          reg_sel_t'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                          8'($urandom_range(0, 255)));
            end
        end
    endtask

    // receiver: short random stall runs, one long hold on request
    initial begin : receiver
        int hold_left;
        int stall_run;
        hold_left = 0;
        stall_run = 0;
        out_ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (!idle_on)
                out_ready <= 1'b1;
            else if (stall_run > 0) begin
                stall_run--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0) begin
                stall_run = $urandom_range(0, 6);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin : stimulus
        bit held;
        bit drained;
        held         = 1'b0;
        drained      = 1'b0;
        rst_n        = 1'b0;
        in_valid     <= 1'b0;
        mode         <= KIND_TICK;
        reg_select   <= REG_CONTROL;
        write_data   <= 8'h00;
        idle_on      = 1'b1;
        hold_req     = 1'b0;
        burst_left   = 0;
        sent         = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // forced toggle, overflow from top, blocked match after a count write
        issue(KIND_WRITE, REG_MASK, 8'hFF);
        issue(KIND_WRITE, REG_COMPARE, 8'h02);
        issue(KIND_WRITE, REG_CONTROL, make_ctl(1'b1, WGM_NORMAL, COM_TOGGLE, CS_DIV1));
        issue(KIND_WRITE, REG_COUNT, 8'hFE);
        repeat (3) issue(KIND_TICK, REG_CONTROL, 8'h00);
        issue(KIND_WRITE, REG_COUNT, 8'h02);
        issue(KIND_TICK, REG_CONTROL, 8'h00);
        issue(KIND_WRITE, REG_COUNT, 8'h01);
        repeat (2) issue(KIND_TICK, REG_CONTROL, 8'h00);
        issue(KIND_READ, REG_FLAGS, 8'h00);
        issue(KIND_WRITE, REG_FLAGS, 8'hFF);
        // ctc wrap on match, then fast pwm with a buffered compare
        issue(KIND_WRITE, REG_CONTROL, make_ctl(1'b0, WGM_CTC, COM_SET, CS_DIV1));
        issue(KIND_WRITE, REG_COUNT, 8'h00);
        repeat (3) issue(KIND_TICK, REG_CONTROL, 8'h00);
        issue(KIND_WRITE, REG_CONTROL, make_ctl(1'b0, WGM_FAST, COM_CLEAR, CS_DIV1));
        issue(KIND_WRITE, REG_COMPARE, 8'h10);
        issue(KIND_WRITE, REG_COUNT, COUNT_TOP);
        repeat (2) issue(KIND_TICK, REG_CONTROL, 8'h00);
        // forced compare ignored in fast pwm, external clocks, phase-correct code
        issue(KIND_WRITE, REG_CONTROL, make_ctl(1'b1, WGM_FAST, COM_SET, CS_EXT_RISE));
        issue(KIND_TICK, REG_CONTROL, 8'h00);
        issue(KIND_WRITE, REG_CONTROL, make_ctl(1'b0, WGM_PHASE, COM_CLEAR, CS_EXT_FALL));
        issue(KIND_READ, REG_CONTROL, 8'h00);
        // unused selects and the unused request kind
        issue(KIND_WRITE, REG_UNUSED_LO, 8'hAA);
        issue(KIND_READ, REG_UNUSED_HI, 8'h00);
        issue(KIND_SPARE, REG_MASK, 8'h55);
        issue(KIND_WRITE, REG_MASK, 8'h00);

        while (sent < ITEM_TARGET) begin
            if (sent >= 500 && !held) begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            idle_on = !(sent >= 800 && sent < 1000);
            if (sent >= 1200 && !drained) begin
                wait_for_drain();
                drained = 1'b1;
            end
            random_segment();
        end

        wait_for_drain();
        repeat (4) @(negedge clk);
        $display("tb: %0d requests sent, %0d results checked", sent, checked);
        $display("tb: %0d timer clocks over normal, ctc and fast pwm setups", timer_clocks);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
